/* rtl/path_oram_access_controller_macros.svh */
// Assertion macros used by the path ORAM access controller.
// Depends on nothing; the macros expand to nothing when SYNTHESIS is defined.
`ifndef PATH_ORAM_ACCESS_CONTROLLER_MACROS_SVH
`define PATH_ORAM_ACCESS_CONTROLLER_MACROS_SVH
`ifndef SYNTHESIS
`define POR_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define POR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define POR_ASSERT(label, clk, rst, prop, msg)
`define POR_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

/* rtl/poram_pkg.sv */
// Constants, word types and path addressing for the path ORAM access controller.
// Depends on nothing.
package poram_pkg;

  localparam int TREE_DEPTH    = 10;
  localparam int BUCKET_SLOTS  = 4;
  localparam int DATA_BITS     = 64;
  localparam int STASH_ENTRIES = 64;

  localparam int NUM_LEAVES  = 1 << TREE_DEPTH;
  localparam int NUM_BUCKETS = 2 * NUM_LEAVES - 1;
  localparam int NUM_BLOCKS  = BUCKET_SLOTS * NUM_BUCKETS;

  localparam int ID_W   = 13;
  localparam int LEAF_W = TREE_DEPTH;
  localparam int NODE_W = TREE_DEPTH + 1;
  localparam int SLOT_W = $clog2(NUM_BLOCKS);
  localparam int LVL_W  = $clog2(TREE_DEPTH + 1);
  localparam int Z_W    = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
  localparam int IDX_W  = $clog2(STASH_ENTRIES);
  localparam int SCAN_W = IDX_W + 1;
  localparam int CNT_W  = 7;

  typedef struct packed {
    logic        kind;
    logic [12:0] block_id;
    logic [63:0] write_data;
    logic [9:0]  new_leaf;
  } poram_req_t;

  typedef struct packed {
    logic [63:0] read_data;
    logic [6:0]  stash_count;
    logic        stash_overflow;
  } poram_rsp_t;

  typedef struct packed {
    logic [ID_W-1:0]      id;
    logic [LEAF_W-1:0]    leaf;
    logic [DATA_BITS-1:0] data;
  } stash_ent_t;

  typedef struct packed {
    logic                 vld;
    logic [ID_W-1:0]      id;
    logic [LEAF_W-1:0]    leaf;
    logic [DATA_BITS-1:0] data;
  } tree_ent_t;

  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] idx;
    stash_ent_t       ent;
  } sel_ent_t;

  // Slot address of slot z in the bucket at level lvl on the path to leaf.
  function automatic logic [SLOT_W-1:0] slot_addr(input logic [LEAF_W-1:0] leaf,
                                                  input logic [LVL_W-1:0]  lvl,
                                                  input logic [Z_W-1:0]    z);
    logic [NODE_W-1:0] node;
    node = NODE_W'((NODE_W'(leaf) + NODE_W'(NUM_LEAVES)) >> (LVL_W'(TREE_DEPTH) - lvl))
           - NODE_W'(1);
    return SLOT_W'(32'(node) * BUCKET_SLOTS + 32'(z));
  endfunction

endpackage

/* rtl/path_oram_access_controller.sv */
// Path ORAM access controller: sequencer, position map, bucket tree and stash.
// Depends on poram_pkg, poram_ram, poram_sel and the assertion macro header.
//
// An access reads the position map, fetches the old path into the stash slot by
// slot, makes one pass over the stash to find the block, and then for each of the
// 11 levels makes one pass over the stash through the sorted selector and writes
// the bucket slot by slot; an id past the tree's capacity goes straight to done.
// The stash scans read one entry a cycle through the stash RAM's single read port.
// After reset a clearing pass writes every position map entry and tree slot, one
// a cycle, with busy high. Results are strobed by done for one cycle and cannot be
// held off by the receiver; busy is already low when that word appears.
`include "path_oram_access_controller_macros.svh"
module path_oram_access_controller (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  poram_pkg::poram_req_t req,
  output logic                  busy,
  output logic                  done,
  output poram_pkg::poram_rsp_t rsp
);
  import poram_pkg::*;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_MAP_RD, S_MAP_WT, S_FETCH_RD, S_FETCH_WT,
    S_ACC_SCAN, S_ACC_DO, S_WB_SCAN, S_WB_PUT, S_DONE
  } state_t;

  state_t                   state;
  logic [SLOT_W-1:0]        init_cnt;
  poram_req_t               cur;
  logic [LEAF_W-1:0]        x;
  logic [LVL_W-1:0]         lvl;
  logic [Z_W-1:0]           zc;
  logic [SCAN_W-1:0]        kc;
  logic [IDX_W-1:0]         pidx;
  logic [STASH_ENTRIES-1:0] svalid;
  logic [CNT_W-1:0]         cnt;
  logic                     ovf;
  logic                     found;
  logic [IDX_W-1:0]         fidx;
  logic [DATA_BITS-1:0]     fdata;
  logic [DATA_BITS-1:0]     res;

  logic                     free_vld;
  logic [IDX_W-1:0]         free_idx;
  logic [LEAF_W-1:0]        nl;
  logic [DATA_BITS-1:0]     wdat;
  logic [DATA_BITS-1:0]     acc_data;
  logic [SLOT_W-1:0]        path_slot;
  logic [LVL_W-1:0]         shamt;
  logic                     pend;
  logic                     last_z;

  logic                     map_we;
  logic [SLOT_W-1:0]        map_waddr;
  logic [LEAF_W-1:0]        map_wdata;
  logic [LEAF_W-1:0]        map_rd;
  logic                     tree_we;
  logic [SLOT_W-1:0]        tree_waddr;
  tree_ent_t                tree_wdata;
  tree_ent_t                tree_rd;
  logic                     st_we;
  logic [IDX_W-1:0]         st_waddr;
  stash_ent_t               st_wdata;
  stash_ent_t               srd;

  logic                     sel_clr;
  sel_ent_t                 cand;
  sel_ent_t                 list [BUCKET_SLOTS];

  assign busy = (state != S_IDLE);

  // Lowest free stash entry.
  always_comb begin
    free_vld = 1'b0;
    free_idx = '0;
    for (int i = STASH_ENTRIES - 1; i >= 0; i--) begin
      if (!svalid[i]) begin
        free_vld = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    nl        = LEAF_W'(cur.new_leaf);
    wdat      = cur.write_data[DATA_BITS-1:0];
    acc_data  = cur.kind ? wdat : (found ? fdata : '0);
    path_slot = slot_addr(x, lvl, zc);
    shamt     = LVL_W'(TREE_DEPTH) - lvl;
    pend      = (kc != '0);
    last_z    = (zc == Z_W'(BUCKET_SLOTS - 1));

    map_we    = (state == S_INIT) || (state == S_MAP_WT);
    map_waddr = (state == S_INIT) ? init_cnt : SLOT_W'(cur.block_id);
    map_wdata = (state == S_INIT) ? '0 : nl;

    tree_we    = (state == S_INIT) || (state == S_WB_PUT);
    tree_waddr = (state == S_INIT) ? init_cnt : path_slot;
    tree_wdata = '0;
    if (state != S_INIT && list[zc].vld) begin
      tree_wdata.vld  = 1'b1;
      tree_wdata.id   = list[zc].ent.id;
      tree_wdata.leaf = list[zc].ent.leaf;
      tree_wdata.data = list[zc].ent.data;
    end

    // The stash takes fetched blocks and the accessed block; the latter keeps
    // its found entry or claims a free one, and always carries the fresh leaf.
    st_we    = ((state == S_FETCH_WT) && tree_rd.vld && free_vld) ||
               ((state == S_ACC_DO) && (found || free_vld));
    st_waddr = (state == S_ACC_DO && found) ? fidx : free_idx;
    if (state == S_FETCH_WT) begin
      st_wdata.id   = tree_rd.id;
      st_wdata.leaf = tree_rd.leaf;
      st_wdata.data = tree_rd.data;
    end else begin
      st_wdata.id   = ID_W'(cur.block_id);
      st_wdata.leaf = nl;
      st_wdata.data = acc_data;
    end

    // A stash block may sit in a bucket when its leaf path shares the bucket.
    cand.vld = (state == S_WB_SCAN) && pend && svalid[pidx] &&
               (((srd.leaf ^ x) >> shamt) == '0);
    cand.idx = pidx;
    cand.ent = srd;
    sel_clr  = (state == S_ACC_DO) || ((state == S_WB_PUT) && last_z);
  end

  poram_ram #(.WIDTH(LEAF_W), .DEPTH(NUM_BLOCKS)) u_map (
    .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
    .raddr(SLOT_W'(cur.block_id)), .rdata(map_rd)
  );

  poram_ram #(.WIDTH($bits(tree_ent_t)), .DEPTH(NUM_BLOCKS)) u_tree (
    .clk(clk), .we(tree_we), .waddr(tree_waddr), .wdata(tree_wdata),
    .raddr(path_slot), .rdata(tree_rd)
  );

  poram_ram #(.WIDTH($bits(stash_ent_t)), .DEPTH(STASH_ENTRIES)) u_stash (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(kc[IDX_W-1:0]), .rdata(srd)
  );

  poram_sel u_sel (
    .clk(clk), .rst(rst), .clr(sel_clr), .cand(cand), .list(list)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      init_cnt <= '0;
      svalid   <= '0;
      cnt      <= '0;
      ovf      <= 1'b0;
      found    <= 1'b0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_INIT: begin
          init_cnt <= init_cnt + SLOT_W'(1);
          if (init_cnt == SLOT_W'(NUM_BLOCKS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            cur <= req;
            res <= '0;
            // An id past the tree's capacity leaves every store untouched.
            state <= (32'(req.block_id) < NUM_BLOCKS) ? S_MAP_RD : S_DONE;
          end
        end
        S_MAP_RD: begin
          state <= S_MAP_WT;
        end
        S_MAP_WT: begin
          x     <= map_rd;
          lvl   <= '0;
          zc    <= '0;
          state <= S_FETCH_RD;
        end
        S_FETCH_RD: begin
          state <= S_FETCH_WT;
        end
        S_FETCH_WT: begin
          if (tree_rd.vld) begin
            if (free_vld) begin
              svalid[free_idx] <= 1'b1;
              cnt              <= cnt + CNT_W'(1);
            end else begin
              ovf <= 1'b1;
            end
          end
          if (last_z) begin
            zc <= '0;
            if (lvl == LVL_W'(TREE_DEPTH)) begin
              kc    <= '0;
              found <= 1'b0;
              state <= S_ACC_SCAN;
            end else begin
              lvl   <= lvl + LVL_W'(1);
              state <= S_FETCH_RD;
            end
          end else begin
            zc    <= zc + Z_W'(1);
            state <= S_FETCH_RD;
          end
        end
        S_ACC_SCAN: begin
          kc   <= kc + SCAN_W'(1);
          pidx <= kc[IDX_W-1:0];
          if (pend && svalid[pidx] && (srd.id == ID_W'(cur.block_id))) begin
            found <= 1'b1;
            fidx  <= pidx;
            fdata <= srd.data;
          end
          if (kc == SCAN_W'(STASH_ENTRIES)) begin
            state <= S_ACC_DO;
          end
        end
        S_ACC_DO: begin
          res <= acc_data;
          if (!found) begin
            if (free_vld) begin
              svalid[free_idx] <= 1'b1;
              cnt              <= cnt + CNT_W'(1);
            end else begin
              ovf <= 1'b1;
            end
          end
          lvl   <= LVL_W'(TREE_DEPTH);
          zc    <= '0;
          kc    <= '0;
          state <= S_WB_SCAN;
        end
        S_WB_SCAN: begin
          kc   <= kc + SCAN_W'(1);
          pidx <= kc[IDX_W-1:0];
          if (kc == SCAN_W'(STASH_ENTRIES)) begin
            state <= S_WB_PUT;
          end
        end
        S_WB_PUT: begin
          if (list[zc].vld) begin
            svalid[list[zc].idx] <= 1'b0;
            cnt                  <= cnt - CNT_W'(1);
          end
          if (last_z) begin
            zc <= '0;
            if (lvl == '0) begin
              state <= S_DONE;
            end else begin
              lvl   <= lvl - LVL_W'(1);
              kc    <= '0;
              state <= S_WB_SCAN;
            end
          end else begin
            zc <= zc + Z_W'(1);
          end
        end
        S_DONE: begin
          done               <= 1'b1;
          rsp.read_data      <= 64'(res);
          rsp.stash_count    <= cnt;
          rsp.stash_overflow <= ovf;
          state              <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `POR_ASSERT(a_cnt_matches, clk, rst, $countones(svalid) == 32'(cnt), "stash count drifted")
  `POR_ASSERT(a_cnt_bound, clk, rst, 32'(cnt) <= STASH_ENTRIES, "stash count past capacity")
  `POR_ASSERT(a_done_idle, clk, rst, !done || !busy, "result word while busy")
  `POR_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy, "accepted word did not start")
  `POR_ASSERT(a_done_count, clk, rst, !done || (rsp.stash_count == cnt), "reported count stale")
endmodule

/* rtl/poram_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module poram_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/poram_sel.sv */
// Sorted selector that keeps the BUCKET_SLOTS smallest block ids seen in one stash scan.
// Depends on poram_pkg.
module poram_sel (
  input  logic               clk,
  input  logic               rst,
  input  logic               clr,
  input  poram_pkg::sel_ent_t cand,
  output poram_pkg::sel_ent_t list [poram_pkg::BUCKET_SLOTS]
);
  import poram_pkg::*;

  logic [BUCKET_SLOTS-1:0] ahead;
  logic [BUCKET_SLOTS-1:0] prev;
  sel_ent_t                up [BUCKET_SLOTS];

  // An entry position is "ahead" when the candidate sorts before what it holds.
  always_comb begin
    for (int i = 0; i < BUCKET_SLOTS; i++) begin
      ahead[i] = !list[i].vld || (cand.ent.id < list[i].ent.id);
    end
    prev  = ahead << 1;
    up[0] = cand;
    for (int i = 1; i < BUCKET_SLOTS; i++) begin
      up[i] = list[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      for (int i = 0; i < BUCKET_SLOTS; i++) begin
        list[i].vld <= 1'b0;
      end
    end else if (cand.vld) begin
      for (int i = 0; i < BUCKET_SLOTS; i++) begin
        if (ahead[i]) begin
          list[i] <= prev[i] ? up[i] : cand;
        end
      end
    end
  end
endmodule
